/* rtl/hvd_pkg.sv */
package hvd_pkg;

	// Q30 working word: angles in radians and unit-range values
	localparam int ZW = 34;
	typedef logic signed [ZW-1:0] q30_t;

	// square root operands: Q60 radicand, Q30 root
	localparam int ROOT_W = 31;
	localparam int RAD_W  = 61;
	typedef logic [ROOT_W-1:0] root_t;
	typedef logic [RAD_W-1:0]  rad_t;

	localparam q30_t            ONE_Q30        = q30_t'(64'sd1 << 30);
	localparam q30_t            GAIN_Q30       = q30_t'(652032874);
	localparam logic [30:0]     DEG2RAD_Q36    = 31'd1199381129;
	localparam logic [28:0]     TWO_RADIUS_Q16 = 29'd450896172;
	localparam logic [29:0]     HALF_CIRC_Q16  = 30'd708266052;

	// arctan(2^-i) in Q30, truncated
	function automatic q30_t atan_q30(input int i);
		logic [31:0] t;
		case (i)
			0:  t = 32'h3243F6A8;
			1:  t = 32'h1DAC6705;
			2:  t = 32'h0FADBAFC;
			3:  t = 32'h07F56EA6;
			4:  t = 32'h03FEAB76;
			5:  t = 32'h01FFD55B;
			6:  t = 32'h00FFFAAA;
			7:  t = 32'h007FFF55;
			8:  t = 32'h003FFFEA;
			9:  t = 32'h001FFFFD;
			10: t = 32'h000FFFFF;
			11: t = 32'h0007FFFF;
			12: t = 32'h0003FFFF;
			13: t = 32'h0001FFFF;
			14: t = 32'h0000FFFF;
			15: t = 32'h00007FFF;
			16: t = 32'h00003FFF;
			17: t = 32'h00001FFF;
			18: t = 32'h00000FFF;
			19: t = 32'h000007FF;
			20: t = 32'h000003FF;
			21: t = 32'h000001FF;
			22: t = 32'h000000FF;
			23: t = 32'h0000007F;
			24: t = 32'h0000003F;
			25: t = 32'h0000001F;
			26: t = 32'h0000000F;
			27: t = 32'h00000008;
			28: t = 32'h00000004;
			29: t = 32'h00000002;
			30: t = 32'h00000001;
			default: t = 32'h00000000;
		endcase
		return q30_t'(t);
	endfunction

endpackage

/* rtl/hvd_angle.sv */
// Wraps a degree value into [-180, 180), takes its magnitude, optionally
// folds it for a cosine, and converts it to Q30 radians (half the angle when not folding). Eight stages.
module hvd_angle #(
	parameter int ANGLE_FRAC_BITS = 20,
	parameter int DW = 31,
	parameter bit FOLD = 1'b0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic signed [DW-1:0] deg,
	output logic                 out_vld,
	output logic                 neg,
	output hvd_pkg::q30_t        ang
);

	localparam int XW = (ANGLE_FRAC_BITS + 12 > 33) ? ANGLE_FRAC_BITS + 12 : 33;
	localparam int RW = XW - ANGLE_FRAC_BITS - 7;
	localparam int MW = ANGLE_FRAC_BITS + 8;
	localparam int WW = ANGLE_FRAC_BITS + 10;
	localparam int SH = ANGLE_FRAC_BITS + 6 + (FOLD ? 0 : 1);
	localparam int PW = MW + 31;
	localparam logic [63:0] FULL  = 64'd360 << ANGLE_FRAC_BITS;
	localparam logic [63:0] HALF  = 64'd180 << ANGLE_FRAC_BITS;
	localparam logic [63:0] QUART = 64'd90 << ANGLE_FRAC_BITS;
	localparam logic [63:0] FH    = FULL + HALF;
	// offset keeps the sum positive and is congruent to HALF modulo FULL
	localparam logic [63:0] OFFS  = HALF + FULL * (((64'd1 << 30) + FULL - 64'd1) / FULL);
	localparam logic [63:0] RECIP = (64'd1 << XW) / FULL;

	logic [7:0] vld_q;

	logic [XW-1:0]        x_s1, x_s2;
	logic [RW-1:0]        q_s2;
	logic [XW-1:0]        r_s3;
	logic signed [WW-1:0] w_s4;
	logic [MW-1:0]        mag_s5, m_s6;
	logic                 neg_s6, neg_s7, neg_s8;
	logic [PW-1:0]        p_s7;
	hvd_pkg::q30_t        ang_s8;

	logic [XW:0]          xsum;
	logic [XW+RW-1:0]     qp;
	logic [XW-1:0]        qf;
	logic [XW:0]          w_c;
	logic [WW-1:0]        m_c;
	logic [PW:0]          rnd;

	always_comb begin
		xsum = (XW+1)'(deg) + (XW+1)'(OFFS);
		qp   = (XW+RW)'(x_s1) * (XW+RW)'(RECIP);
		qf   = XW'(q_s2) * XW'(FULL);
		if (r_s3 >= XW'(FULL)) begin
			w_c = (XW+1)'(r_s3) - (XW+1)'(FH);
		end else begin
			w_c = (XW+1)'(r_s3) - (XW+1)'(HALF);
		end
		m_c = w_s4[WW-1] ? WW'(-w_s4) : WW'(w_s4);
		rnd = (PW+1)'(p_s7) + ((PW+1)'(1) << (SH - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[6:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= xsum[XW-1:0];
			x_s2   <= x_s1;
			q_s2   <= qp[XW+RW-1:XW];
			r_s3   <= x_s2 - qf;
			w_s4   <= w_c[WW-1:0];
			mag_s5 <= m_c[MW-1:0];
			if (FOLD && (MW'(QUART) < mag_s5)) begin
				m_s6   <= MW'(HALF) - mag_s5;
				neg_s6 <= 1'b1;
			end else begin
				m_s6   <= mag_s5;
				neg_s6 <= 1'b0;
			end
			p_s7   <= PW'(m_s6) * PW'(hvd_pkg::DEG2RAD_Q36);
			neg_s7 <= neg_s6;
			ang_s8 <= hvd_pkg::q30_t'(rnd >> SH);
			neg_s8 <= neg_s7;
		end
	end

	assign out_vld = vld_q[7];
	assign neg     = neg_s8;
	assign ang     = ang_s8;

endmodule

/* rtl/hvd_cordic.sv */
// Unrolled CORDIC, one iteration per stage. VECTOR selects vectoring mode.
module hvd_cordic #(
	parameter int STEPS = 24,
	parameter bit VECTOR = 1'b0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic          in_tag,
	input  hvd_pkg::q30_t x0,
	input  hvd_pkg::q30_t y0,
	input  hvd_pkg::q30_t z0,
	output logic          out_vld,
	output logic          out_tag,
	output hvd_pkg::q30_t x,
	output hvd_pkg::q30_t y,
	output hvd_pkg::q30_t z
);

	hvd_pkg::q30_t x_s [0:STEPS-1];
	hvd_pkg::q30_t y_s [0:STEPS-1];
	hvd_pkg::q30_t z_s [0:STEPS-1];
	logic          tag_s [0:STEPS-1];
	logic          vld_s [0:STEPS-1];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		hvd_pkg::q30_t xi, yi, zi, dx, dy, at, xn, yn, zn;
		logic          ti, vi;

		if (i == 0) begin : g_first
			assign xi = x0;
			assign yi = y0;
			assign zi = z0;
			assign ti = in_tag;
			assign vi = in_vld;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign ti = tag_s[i-1];
			assign vi = vld_s[i-1];
		end

		always_comb begin
			dx = yi >>> i;
			dy = xi >>> i;
			at = hvd_pkg::atan_q30(i);
			if (VECTOR) begin
				if (yi > hvd_pkg::q30_t'(0)) begin
					xn = xi + dx;
					yn = yi - dy;
					zn = zi + at;
				end else begin
					xn = xi - dx;
					yn = yi + dy;
					zn = zi - at;
				end
			end else begin
				if (!zi[hvd_pkg::ZW-1]) begin
					xn = xi - dx;
					yn = yi + dy;
					zn = zi - at;
				end else begin
					xn = xi + dx;
					yn = yi - dy;
					zn = zi + at;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i]   <= xn;
				y_s[i]   <= yn;
				z_s[i]   <= zn;
				tag_s[i] <= ti;
			end
		end
	end

	assign out_vld = vld_s[STEPS-1];
	assign out_tag = tag_s[STEPS-1];
	assign x       = x_s[STEPS-1];
	assign y       = y_s[STEPS-1];
	assign z       = z_s[STEPS-1];

endmodule

/* rtl/hvd_isqrt.sv */
// Floor square root, one result bit per stage, remainder kept as v - root^2.
module hvd_isqrt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  hvd_pkg::rad_t  v,
	output logic           out_vld,
	output hvd_pkg::root_t root
);

	localparam int NS = hvd_pkg::ROOT_W;
	localparam int RW = hvd_pkg::RAD_W;
	localparam int TW = 2 * NS + 1;

	hvd_pkg::rad_t  rem_s  [0:NS-1];
	hvd_pkg::root_t root_s [0:NS-1];
	logic           vld_s  [0:NS-1];

	for (genvar j = 0; j < NS; j++) begin : g_bit
		localparam int K = NS - 1 - j;
		hvd_pkg::rad_t  ri, rn;
		hvd_pkg::root_t qi, qn;
		logic           vi;
		logic [TW-1:0]  term;

		if (j == 0) begin : g_first
			assign ri = v;
			assign qi = '0;
			assign vi = in_vld;
		end else begin : g_next
			assign ri = rem_s[j-1];
			assign qi = root_s[j-1];
			assign vi = vld_s[j-1];
		end

		// root bits sit above K, so the two terms never overlap
		always_comb begin
			term = (TW'(qi) << (K + 1)) | (TW'(1) << (2 * K));
			if (TW'(ri) >= term) begin
				rn = RW'(TW'(ri) - term);
				qn = qi | (NS'(1) << K);
			end else begin
				rn = ri;
				qn = qi;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= rn;
				root_s[j] <= qn;
			end
		end
	end

	assign out_vld = vld_s[NS-1];
	assign root    = root_s[NS-1];

endmodule

/* rtl/haversine_distance.sv */
// channel | handshake             | payload
// input   | in_valid / in_ready   | lon_a, lat_a, lon_b, lat_b
// output  | out_valid / out_ready | distance_nm
//
// One coordinate pair per clock while in_ready is high; the pipeline runs through
// the rotation CORDIC, the 31-stage square root and the vectoring CORDIC.
// Reset clears only valid bits; payload registers are left as they are.
// A held result waits in the output register, the next one in a skid register;
// the whole pipeline holds only while the skid register is full.
module haversine_distance #(
	parameter int CORDIC_STEPS = 24,
	parameter int ANGLE_FRAC_BITS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [29:0] lon_a,
	input  logic signed [27:0] lat_a,
	input  logic signed [29:0] lon_b,
	input  logic signed [27:0] lat_b,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [29:0]        distance_nm
);

	localparam int ZW = hvd_pkg::ZW;

	logic adv;
	logic signed [28:0] dlat;
	logic signed [30:0] dlon;

	logic vld_ang, vld_rot, vld_sq, vld_vec;
	logic neg_a, neg_b, tag_a, tag_b;
	hvd_pkg::q30_t ang_dlat, ang_dlon, ang_a, ang_b;
	hvd_pkg::q30_t x_a, x_b, y_lat, y_lon;

	hvd_pkg::q30_t sl_s1, sn_s1, ca_s1, cb_s1;
	hvd_pkg::q30_t slat_s2, slon_s2, cc_s2;
	hvd_pkg::q30_t slat_s3, p_s3;
	hvd_pkg::q30_t sum_s4;
	logic [30:0]   a_s5, b_s5;
	logic [30:0]   zc_s6;
	logic [59:0]   prod_s7;
	logic [30:0]   rnd_s8;
	logic [29:0]   dist_s9;
	logic [9:1]    v_s;

	logic signed [2*ZW-1:0] m_sl, m_sn, m_cc, m_p;
	hvd_pkg::q30_t          bs, z_vec;
	hvd_pkg::root_t         sa, sb;
	logic [60:0]            rnd_c;

	logic        out_vld_q, skid_vld_q;
	logic [29:0] out_q, skid_q;

	assign adv      = !skid_vld_q;
	assign in_ready = adv;
	assign dlat     = 29'(lat_b) - 29'(lat_a);
	assign dlon     = 31'(lon_b) - 31'(lon_a);

	hvd_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .DW(29), .FOLD(1'b0)) u_ang_dlat (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(in_valid), .deg(dlat),
		.out_vld(vld_ang), .neg(), .ang(ang_dlat)
	);
	hvd_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .DW(31), .FOLD(1'b0)) u_ang_dlon (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(in_valid), .deg(dlon),
		.out_vld(), .neg(), .ang(ang_dlon)
	);
	hvd_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .DW(28), .FOLD(1'b1)) u_ang_lat_a (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(in_valid), .deg(lat_a),
		.out_vld(), .neg(neg_a), .ang(ang_a)
	);
	hvd_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .DW(28), .FOLD(1'b1)) u_ang_lat_b (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(in_valid), .deg(lat_b),
		.out_vld(), .neg(neg_b), .ang(ang_b)
	);

	hvd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_dlat (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(vld_ang), .in_tag(1'b0),
		.x0(hvd_pkg::GAIN_Q30), .y0('0), .z0(ang_dlat),
		.out_vld(vld_rot), .out_tag(), .x(), .y(y_lat), .z()
	);
	hvd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_dlon (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(vld_ang), .in_tag(1'b0),
		.x0(hvd_pkg::GAIN_Q30), .y0('0), .z0(ang_dlon),
		.out_vld(), .out_tag(), .x(), .y(y_lon), .z()
	);
	hvd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_lat_a (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(vld_ang), .in_tag(neg_a),
		.x0(hvd_pkg::GAIN_Q30), .y0('0), .z0(ang_a),
		.out_vld(), .out_tag(tag_a), .x(x_a), .y(), .z()
	);
	hvd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_lat_b (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(vld_ang), .in_tag(neg_b),
		.x0(hvd_pkg::GAIN_Q30), .y0('0), .z0(ang_b),
		.out_vld(), .out_tag(tag_b), .x(x_b), .y(), .z()
	);

	always_comb begin
		m_sl  = sl_s1 * sl_s1;
		m_sn  = sn_s1 * sn_s1;
		m_cc  = ca_s1 * cb_s1;
		m_p   = cc_s2 * slon_s2;
		bs    = hvd_pkg::ONE_Q30 - sum_s4;
		rnd_c = 61'(prod_s7) + (61'(1) << 29);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s[1] <= vld_rot;
			v_s[2] <= v_s[1];
			v_s[3] <= v_s[2];
			v_s[4] <= v_s[3];
			v_s[5] <= v_s[4];
			v_s[6] <= vld_vec;
			v_s[7] <= v_s[6];
			v_s[8] <= v_s[7];
			v_s[9] <= v_s[8];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sl_s1   <= y_lat;
			sn_s1   <= y_lon;
			ca_s1   <= tag_a ? -x_a : x_a;
			cb_s1   <= tag_b ? -x_b : x_b;
			slat_s2 <= hvd_pkg::q30_t'(m_sl >>> 30);
			slon_s2 <= hvd_pkg::q30_t'(m_sn >>> 30);
			cc_s2   <= hvd_pkg::q30_t'(m_cc >>> 30);
			slat_s3 <= slat_s2;
			p_s3    <= hvd_pkg::q30_t'(m_p >>> 30);
			sum_s4  <= slat_s3 + p_s3;
			// clamp a and 1 - a to [0, 1] side by side
			if (sum_s4[ZW-1]) begin
				a_s5 <= '0;
			end else if (sum_s4 > hvd_pkg::ONE_Q30) begin
				a_s5 <= 31'(hvd_pkg::ONE_Q30);
			end else begin
				a_s5 <= sum_s4[30:0];
			end
			if (bs[ZW-1]) begin
				b_s5 <= '0;
			end else if (bs > hvd_pkg::ONE_Q30) begin
				b_s5 <= 31'(hvd_pkg::ONE_Q30);
			end else begin
				b_s5 <= bs[30:0];
			end
			zc_s6   <= z_vec[ZW-1] ? '0 : z_vec[30:0];
			prod_s7 <= 60'(zc_s6) * 60'(hvd_pkg::TWO_RADIUS_Q16);
			rnd_s8  <= rnd_c[60:30];
			dist_s9 <= (rnd_s8 > 31'(hvd_pkg::HALF_CIRC_Q16)) ? hvd_pkg::HALF_CIRC_Q16
				: rnd_s8[29:0];
		end
	end

	hvd_isqrt u_sqrt_a (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(v_s[5]),
		.v({a_s5, 30'd0}), .out_vld(vld_sq), .root(sa)
	);
	hvd_isqrt u_sqrt_b (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(v_s[5]),
		.v({b_s5, 30'd0}), .out_vld(), .root(sb)
	);

	hvd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1)) u_vec (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(vld_sq), .in_tag(1'b0),
		.x0(hvd_pkg::q30_t'(sb)), .y0(hvd_pkg::q30_t'(sa)), .z0('0),
		.out_vld(vld_vec), .out_tag(), .x(), .y(), .z(z_vec)
	);

	// output register plus skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || out_ready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= v_s[9];
			end
		end else if (v_s[9] && adv) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_ready) begin
			out_q <= skid_vld_q ? skid_q : dist_s9;
		end else if (v_s[9] && adv) begin
			skid_q <= dist_s9;
		end
	end

	assign out_valid   = out_vld_q;
	assign distance_nm = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid register full while output register empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !out_ready))
		else $error("skid register filled without a held output");

	a_dist_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (distance_nm <= hvd_pkg::HALF_CIRC_Q16))
		else $error("distance above half circumference");

endmodule

/* tb/tb_haversine_distance.sv */
`timescale 1ns / 1ps

module tb_haversine_distance;

	localparam int STEPS = 24;
	localparam int FRAC = 20;
	localparam int LATENCY = 2 * STEPS + 49;
	localparam longint DEG = longint'(1) << FRAC;
	localparam longint LON_MAX = 377487360;
	localparam longint LAT_MAX = 94371840;
	localparam longint UNIT = longint'(1) << 30;
	localparam longint DEG2RAD = 1199381129;
	localparam longint RADIUS_NM = 225448086;
	localparam longint HALF_CIRC = 708266052;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [29:0] lon_a;
	logic signed [27:0] lat_a;
	logic signed [29:0] lon_b;
	logic signed [27:0] lat_b;
	logic               out_valid;
	logic               out_ready;
	logic [29:0]        distance_nm;

	logic [29:0] dist_queue[$];
	int          err_count;
	int          burst_left;
	int          stall_mode;

	haversine_distance #(.CORDIC_STEPS(STEPS), .ANGLE_FRAC_BITS(FRAC)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.lon_a(lon_a), .lat_a(lat_a), .lon_b(lon_b), .lat_b(lat_b),
		.out_valid(out_valid), .out_ready(out_ready), .distance_nm(distance_nm)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic longint atan_tab(input int i);
		longint t[32] = '{
			64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
			64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
			64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
			64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
			64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
			64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
			64'h00000001, 64'h00000000};
		return t[i];
	endfunction

	function automatic longint wrap_angle(input longint d);
		longint full, r;
		full = 360 * DEG;
		r = d % full;
		if (r < 0)
			r += full;
		if (r >= 180 * DEG)
			r -= full;
		return r;
	endfunction

	function automatic longint to_radians(input longint mag, input int extra);
		int sh;
		longint unsigned p;
		sh = FRAC + 6 + extra;
		p = longint'(mag) * DEG2RAD + (longint'(1) << (sh - 1));
		return longint'(p >> sh);
	endfunction

	function automatic void cordic_rotate(input longint ang, output longint c,
			output longint s);
		longint x, y, z, dx, dy;
		x = 652032874;
		y = 0;
		z = ang;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tab(i);
			end else begin
				x += dx; y -= dy; z += atan_tab(i);
			end
		end
		c = x;
		s = y;
	endfunction

	function automatic longint half_sin_sq(input longint d);
		longint r, c, s;
		r = wrap_angle(d);
		if (r < 0)
			r = -r;
		cordic_rotate(to_radians(r, 1), c, s);
		return (s * s) >>> 30;
	endfunction

	function automatic longint cosine(input longint d);
		longint r, c, s;
		bit neg;
		r = wrap_angle(d);
		if (r < 0)
			r = -r;
		neg = 0;
		if (r > 90 * DEG) begin
			r = 180 * DEG - r;
			neg = 1;
		end
		cordic_rotate(to_radians(r, 0), c, s);
		return neg ? -c : c;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint vector_atan(input longint x, input longint y);
		longint z, dx, dy;
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += atan_tab(i);
			end else begin
				x -= dx; y += dy; z -= atan_tab(i);
			end
		end
		return z;
	endfunction

	function automatic logic [29:0] great_circle_nm(input longint la_lon, input longint la_lat,
			input longint lb_lon, input longint lb_lat);
		longint s_lat, s_lon, cc, a, sa, sb, z;
		longint unsigned nm_q16;
		s_lat = half_sin_sq(lb_lat - la_lat);
		s_lon = half_sin_sq(lb_lon - la_lon);
		cc = (cosine(la_lat) * cosine(lb_lat)) >>> 30;
		a = s_lat + ((cc * s_lon) >>> 30);
		if (a < 0)
			a = 0;
		if (a > UNIT)
			a = UNIT;
		sa = longint'(int_sqrt(longint'(a) << 30));
		sb = longint'(int_sqrt(longint'(UNIT - a) << 30));
		z = vector_atan(sb, sa);
		if (z < 0)
			z = 0;
		nm_q16 = (longint'(z) * 2 * RADIUS_NM + (longint'(1) << 29)) >> 30;
		if (nm_q16 > HALF_CIRC)
			nm_q16 = HALF_CIRC;
		return nm_q16[29:0];
	endfunction

	// value as the port of width w carries it
	function automatic longint sign_ext(input longint v, input int w);
		longint r;
		r = v & ((longint'(1) << w) - 1);
		if (r[w-1])
			r -= longint'(1) << w;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	// sender: bursts with random gaps between them
	task automatic send_pair(input longint a_lon, input longint a_lat,
			input longint b_lon, input longint b_lat);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0)
				in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1'b1;
		lon_a <= 30'(a_lon);
		lat_a <= 28'(a_lat);
		lon_b <= 30'(b_lon);
		lat_b <= 28'(b_lat);
		dist_queue.push_back(great_circle_nm(sign_ext(a_lon, 30), sign_ext(a_lat, 28),
			sign_ext(b_lon, 30), sign_ext(b_lat, 28)));
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic longint rnd_span(input longint lim);
		return longint'($urandom_range(0, 32'(2 * lim))) - lim;
	endfunction

	function automatic longint rnd_field(input int w, input longint lim);
		int pick;
		longint v;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			v = longint'({$urandom, $urandom});
		else if (pick == 1)
			v = ($urandom_range(0, 1) ? lim : -lim) + longint'($urandom_range(0, 8)) - 4;
		else
			v = rnd_span(lim);
		v = v & ((longint'(1) << w) - 1);
		if (v[w-1])
			v -= longint'(1) << w;
		return v;
	endfunction

	// receiver: stalls on a pattern that changes now and then
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_mode <= 0;
		end else begin
			if ($urandom_range(0, 199) == 0)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 3) != 0;
				2: out_ready <= $urandom_range(0, 1);
				default: out_ready <= $urandom_range(0, 7) == 0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (dist_queue.size() == 0)
				report_mismatch("unexpected transfer", distance_nm, -1);
			else if (distance_nm !== dist_queue[0]) begin
				report_mismatch("distance_nm", distance_nm, dist_queue[0]);
				void'(dist_queue.pop_front());
			end else
				void'(dist_queue.pop_front());
		end
	end

	task automatic test_directed();
		send_pair(0, 0, 0, 0);
		send_pair(LON_MAX, LAT_MAX, -LON_MAX, -LAT_MAX);
		send_pair(-LON_MAX, -LAT_MAX, LON_MAX, LAT_MAX);
		send_pair(0, LAT_MAX, 0, -LAT_MAX);
		send_pair(0, 0, 180 * DEG, 0);
		send_pair(0, 0, -180 * DEG, 0);
		send_pair(-(longint'(1) << 29), -(longint'(1) << 27),
			(longint'(1) << 29) - 1, (longint'(1) << 27) - 1);
		send_pair((longint'(1) << 29) - 1, (longint'(1) << 27) - 1, 0, 0);
		send_pair(10 * DEG, 45 * DEG, 10 * DEG + 1, 45 * DEG);
		send_pair(0, 100 * DEG, 0, -100 * DEG);
		send_pair(0, 120 * DEG, 90 * DEG, 30 * DEG);
		send_pair(179 * DEG, 0, -179 * DEG, 0);
		send_pair(0, 0, 179 * DEG + DEG / 2, 1);
		send_pair(45 * DEG, 0, 225 * DEG, 0);
		send_pair(0, 90 * DEG, 123 * DEG, 90 * DEG);
		send_pair(-1, -1, 1, 1);
		send_pair(30 * DEG, 60 * DEG, -150 * DEG, -60 * DEG);
		send_pair(0, 90 * DEG - 1, 0, 90 * DEG + 1);
	endtask

	task automatic test_random();
		for (int n = 0; n < 1300; n++)
			send_pair(rnd_field(30, LON_MAX), rnd_field(28, LAT_MAX),
				rnd_field(30, LON_MAX), rnd_field(28, LAT_MAX));
	endtask

	// pairs close together and nearly antipodal
	task automatic test_near_far();
		longint lo, la, d;
		for (int n = 0; n < 630; n++) begin
			lo = rnd_span(LON_MAX / 2);
			la = rnd_span(LAT_MAX);
			d = longint'($urandom_range(0, 4096)) - 2048;
			if (n % 2 == 0)
				send_pair(lo, la, lo + d, la - d);
			else
				send_pair(lo, la, lo + 180 * DEG + d, -la + d);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		lon_a = '0;
		lat_a = '0;
		lon_b = '0;
		lat_b = '0;
		err_count = 0;
		burst_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_near_far();
		in_valid <= 1'b0;
		while (dist_queue.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#4000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
